FILE: rtl/core/spi9_pkg.sv
// Shared types, register codes and frame constants of the SPI master core.
package spi9_pkg;

    localparam int WORD_W     = 9;
    localparam int BIT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [BIT_IDX_W-1:0] t_bit_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes of the configuration port
    localparam t_cfg_idx CFG_CLOCK_DIVISOR  = 3'd0;
    localparam t_cfg_idx CFG_CLOCK_POLARITY = 3'd1;
    localparam t_cfg_idx CFG_CLOCK_PHASE    = 3'd2;
    localparam t_cfg_idx CFG_MSB_FIRST      = 3'd3;
    localparam t_cfg_idx CFG_ENABLE         = 3'd4;

    localparam t_word    BIT_NINE_MASK = 9'h100;
    localparam t_word    LOW_BYTE_MASK = 9'h0FF;
    localparam t_bit_idx FRAME_BITS_8  = 4'd8;
    localparam t_bit_idx FRAME_BITS_9  = 4'd9;
    // Bit position meaning "no current bit"
    localparam t_bit_idx BIT_NONE      = 4'd9;

    typedef struct packed {
        logic clock_polarity;
        logic clock_phase;
        logic msb_first;
        logic enable;
    } t_spi9_cfg;

    typedef struct packed {
        logic  sclk;
        logic  mosi;
        logic  busy_res;
        logic  done_res;
        t_word rx_data;
    } t_spi9_result;

endpackage

FILE: rtl/core/spi9_in_if.sv
// Input channel: one system tick carrying start request, mode, tx word and MISO.
interface spi9_in_if;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic               mode;
    spi9_pkg::t_word    tx_data;
    logic               miso;

    modport source (output valid, output start_req, output mode, output tx_data,
                    output miso, input ready);
    modport sink   (input valid, input start_req, input mode, input tx_data,
                    input miso, output ready);
endinterface

FILE: rtl/core/spi9_out_if.sv
// Output channel: pin levels, status and received word for one tick.
interface spi9_out_if;
    logic               valid;
    logic               ready;
    logic               sclk;
    logic               mosi;
    logic               busy_res;
    logic               done_res;
    spi9_pkg::t_word    rx_data;

    modport source (output valid, output sclk, output mosi, output busy_res,
                    output done_res, output rx_data, input ready);
    modport sink   (input valid, input sclk, input mosi, input busy_res,
                    input done_res, input rx_data, output ready);
endinterface

FILE: rtl/core/spi9_engine.sv
// Frame state machine: half-period timing, bit shifting and MISO sampling per tick.
module spi9_engine #(
    parameter int DIVISOR_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_start_req,
    input  logic                       i_mode,
    input  spi9_pkg::t_word            i_tx_data,
    input  logic                       i_miso,
    input  spi9_pkg::t_spi9_cfg        i_cfg,
    input  logic [DIVISOR_WIDTH-1:0]   i_divisor,
    output spi9_pkg::t_spi9_result     o_result
);
    import spi9_pkg::*;

    logic                     r_active, n_active;
    logic [DIVISOR_WIDTH-1:0] r_tick, n_tick;
    logic                     r_second_half, n_second_half;
    t_bit_idx                 r_bits_left, n_bits_left;
    logic                     r_nine, n_nine;
    t_word                    r_tx_shift, n_tx_shift;
    t_word                    r_rx_shift, n_rx_shift;
    t_word                    r_rx_hold, n_rx_hold;

    logic [DIVISOR_WIDTH-1:0] div_eff;
    logic [DIVISOR_WIDTH-1:0] tick_inc;
    t_bit_idx                 sample_idx;
    t_bit_idx                 out_idx;
    logic                     done;
    logic                     sample_now;

    function automatic t_bit_idx cur_index(input t_bit_idx bits_left, input logic nine,
                                           input logic msb_first);
        t_bit_idx n;
        n = nine ? FRAME_BITS_9 : FRAME_BITS_8;
        if (bits_left == '0 || bits_left > n)
            return BIT_NONE;
        return msb_first ? t_bit_idx'(bits_left - 1'b1) : t_bit_idx'(n - bits_left);
    endfunction

    assign div_eff    = (i_divisor == '0) ? DIVISOR_WIDTH'(1) : i_divisor;
    assign tick_inc   = r_tick + 1'b1;
    assign sample_idx = cur_index(r_bits_left, r_nine, i_cfg.msb_first);

    always_comb begin
        n_active      = r_active;
        n_tick        = r_tick;
        n_second_half = r_second_half;
        n_bits_left   = r_bits_left;
        n_nine        = r_nine;
        n_tx_shift    = r_tx_shift;
        n_rx_shift    = r_rx_shift;
        n_rx_hold     = r_rx_hold;
        done          = 1'b0;
        sample_now    = 1'b0;

        if (!i_cfg.enable) begin
            n_active      = 1'b0;
            n_tick        = '0;
            n_second_half = 1'b0;
            n_bits_left   = '0;
        end else if (r_active) begin
            if (tick_inc >= div_eff) begin
                n_tick = '0;
                if (!r_second_half) begin
                    n_second_half = 1'b1;
                    sample_now    = !i_cfg.clock_phase;
                end else begin
                    n_second_half = 1'b0;
                    sample_now    = i_cfg.clock_phase;
                    n_bits_left   = r_bits_left - 1'b1;
                end
            end else begin
                n_tick = tick_inc;
            end
        end else if (i_start_req) begin
            n_active      = 1'b1;
            n_tick        = '0;
            n_second_half = 1'b0;
            n_nine        = i_mode;
            n_bits_left   = i_mode ? FRAME_BITS_9 : FRAME_BITS_8;
            n_tx_shift    = i_mode ? (i_tx_data & (BIT_NINE_MASK | LOW_BYTE_MASK))
                                   : (i_tx_data & LOW_BYTE_MASK);
            n_rx_shift    = '0;
        end

        if (sample_now && sample_idx < BIT_NONE)
            n_rx_shift[sample_idx] = i_miso;

        // Frame ends after the trailing half of its last bit
        if (i_cfg.enable && r_active && r_second_half && tick_inc >= div_eff
            && n_bits_left == '0) begin
            n_active  = 1'b0;
            n_rx_hold = n_rx_shift;
            done      = 1'b1;
        end
    end

    assign out_idx = cur_index(n_bits_left, n_nine, i_cfg.msb_first);

    always_comb begin
        o_result.busy_res = n_active;
        o_result.done_res = done;
        o_result.rx_data  = n_rx_hold;
        if (n_active) begin
            o_result.sclk = i_cfg.clock_polarity ^ (i_cfg.clock_phase ? !n_second_half
                                                                      : n_second_half);
            o_result.mosi = (out_idx < BIT_NONE) ? n_tx_shift[out_idx] : 1'b0;
        end else begin
            o_result.sclk = i_cfg.clock_polarity;
            o_result.mosi = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_tick        <= '0;
            r_second_half <= 1'b0;
            r_bits_left   <= '0;
            r_nine        <= 1'b0;
            r_tx_shift    <= '0;
            r_rx_shift    <= '0;
            r_rx_hold     <= '0;
        end else if (i_step) begin
            r_active      <= n_active;
            r_tick        <= n_tick;
            r_second_half <= n_second_half;
            r_bits_left   <= n_bits_left;
            r_nine        <= n_nine;
            r_tx_shift    <= n_tx_shift;
            r_rx_shift    <= n_rx_shift;
            r_rx_hold     <= n_rx_hold;
        end
    end

endmodule

FILE: rtl/core/spi_master_8_or_9_bit_core.sv
// SPI master core: configuration registers, frame engine and output register.
//
// Usage: each transaction on i_in is one system tick of the SPI master. It carries
// start_req, mode (0: 8-bit frame, 1: 9-bit frame), tx_data and the sampled MISO
// level. For every accepted tick the core delivers exactly one transaction on o_out
// with the SCLK and MOSI levels, busy_res, a one-tick done_res pulse and the last
// received word rx_data, all as they stand after that tick.
// The result of an accepted tick is registered and shown on o_out right after the edge that accepts it.
// Throughput is one tick per cycle while the receiver keeps o_out.ready high; the frame
// state update closes through the engine's compare and shift logic.
// The input side stays ready while the output register is empty or being drained,
// so a stalled receiver holds i_in off only while a result is waiting.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata, one register
// per write, while no tick is in flight.
// Reset (synchronous, active low) clears the frame state and the received word and
// loads divisor 4, CPOL 0, CPHA 0, MSB first and enabled; o_out is empty after reset.
module spi_master_8_or_9_bit_core #(
    parameter int DIVISOR_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spi9_in_if.sink                       i_in,
    spi9_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  spi9_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [spi9_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import spi9_pkg::*;

    logic [DIVISOR_WIDTH-1:0] r_divisor;
    t_spi9_cfg                r_cfg;
    t_spi9_result             r_res;
    t_spi9_result             eng_res;
    logic                     r_out_valid;
    logic                     step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor            <= DIVISOR_WIDTH'(4);
            r_cfg.clock_polarity <= 1'b0;
            r_cfg.clock_phase    <= 1'b0;
            r_cfg.msb_first      <= 1'b1;
            r_cfg.enable         <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLOCK_DIVISOR:  r_divisor            <= i_cfg_wdata[DIVISOR_WIDTH-1:0];
                CFG_CLOCK_POLARITY: r_cfg.clock_polarity <= i_cfg_wdata[0];
                CFG_CLOCK_PHASE:    r_cfg.clock_phase    <= i_cfg_wdata[0];
                CFG_MSB_FIRST:      r_cfg.msb_first      <= i_cfg_wdata[0];
                CFG_ENABLE:         r_cfg.enable         <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    spi9_engine #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_start_req (i_in.start_req),
        .i_mode      (i_in.mode),
        .i_tx_data   (i_in.tx_data),
        .i_miso      (i_in.miso),
        .i_cfg       (r_cfg),
        .i_divisor   (r_divisor),
        .o_result    (eng_res)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= eng_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.sclk     = r_res.sclk;
    assign o_out.mosi     = r_res.mosi;
    assign o_out.busy_res = r_res.busy_res;
    assign o_out.done_res = r_res.done_res;
    assign o_out.rx_data  = r_res.rx_data;

endmodule
